/* rtl/aofb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aofb_pkg
// Shared types, constants and AES helper functions for the OFB cipher.
// ----------------------------------------------------------------------------
package aofb_pkg;

  localparam int BlockBytes = 16;
  localparam int QueueDepth = 4;
  localparam int AddrW      = 6;

  localparam logic [2:0] RegKey0 = 3'd0;
  localparam logic [2:0] RegKey1 = 3'd1;
  localparam logic [2:0] RegKey2 = 3'd2;
  localparam logic [2:0] RegKey3 = 3'd3;
  localparam logic [2:0] RegKlen = 3'd4;
  localparam logic [2:0] RegIvHi = 3'd5;
  localparam logic [2:0] RegIvLo = 3'd6;

  localparam logic [1:0] Klen128 = 2'd0;
  localparam logic [1:0] Klen192 = 2'd1;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [255:0] key;
    logic [1:0]   klen;
    logic [127:0] iv;
  } cfg_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] subw(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // byte 0 of the state is bits 127:120
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic final_rnd);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int i = 0; i < 16; i++) t[i] = sbox(b[(i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)]);
    if (!final_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o ^ rk;
  endfunction

endpackage

/* rtl/aofb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aofb_if
// Valid/ready stream channel carrying one byte beat.
// ----------------------------------------------------------------------------
interface aofb_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       restart;
  logic       last;
  modport source (output valid, output data, output restart, output last, input ready);
  modport sink   (input valid, input data, input restart, input last, output ready);
endinterface

/* rtl/aofb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aofb_front
// Input side: accepts beats and buffers them in a short queue.
// ----------------------------------------------------------------------------
module aofb_front #(
  parameter int Depth = 4
) (
  input  logic            clk,
  input  logic            rst,
  aofb_if.sink            in_ch,
  output aofb_pkg::beat_t q_beat,
  output logic            q_valid,
  input  logic            q_pop
);
  import aofb_pkg::*;
  localparam int PW = $clog2(Depth);

  beat_t        mem [Depth];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   cnt;
  logic          push;

  assign in_ch.ready = (cnt != (PW+1)'(Depth));
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt != '0);
  assign q_beat  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= '{data: in_ch.data, restart: in_ch.restart, last: in_ch.last};
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(Depth-1)) ? '0 : wp + 1'b1;
      if (q_pop && q_valid) rp <= (rp == PW'(Depth-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(q_pop && q_valid);
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    cnt <= (PW+1)'(Depth)) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (push && !(q_pop && q_valid)) |=> cnt == $past(cnt) + 1'b1) else $error("count slip");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) |-> !q_valid) else $error("empty pop");
`endif
endmodule

/* rtl/aofb_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aofb_core
// Iterative AES engine: one key-expansion word and per-round steps.
// ----------------------------------------------------------------------------
module aofb_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [127:0]     blk_in,
  input  aofb_pkg::cfg_t   cfg,
  output logic             busy,
  output logic             done,
  output logic [127:0]     blk_out
);
  import aofb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_KEY, S_RND} st_t;
  st_t st;

  // sliding window of last 8 key words; rk words produced one per cycle
  logic [31:0] w [8];
  logic [5:0]  wi, total;
  logic [2:0]  nk, ki;
  logic [7:0]  rcon;
  logic [3:0]  nr, rnd;
  logic [127:0] rkq [15];
  logic [127:0] s;
  logic [31:0]  t, nw;
  logic [3:0]   nk4;

  assign nk4 = (cfg.klen == Klen128) ? 4'd4 : (cfg.klen == Klen192) ? 4'd6 : 4'd8;
  assign busy = (st != S_IDLE);
  assign blk_out = s;

  always_comb begin
    t = w[7];
    if (ki == 3'd0) t = subw({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
    else if (nk4 == 4'd8 && ki == 3'd4) t = subw(t);
    nw = t ^ w[3'(8 - nk4)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; done <= 1'b0;
    end else begin
      done <= (st == S_RND) && (rnd == nr);
      case (st)
        S_IDLE: begin
          if (start) begin
            // window holds key aligned so w[7] is newest
            for (int i = 0; i < 8; i++)
              w[i] <= cfg.key[255 - 32 * int'(3'(i + nk4)) -: 32];
            nk <= nk4[2:0];
            // the first key words fill rk0 and, for longer keys, part or all of rk1
            rkq[0] <= cfg.key[255:128];
            if (nk4 == 4'd8) rkq[1] <= cfg.key[127:0];
            else if (nk4 == 4'd6) rkq[1][127:64] <= cfg.key[127:64];
            nr <= nk4 + 4'd6;
            total <= 6'((nk4 + 6 + 1) * 4);
            wi <= 6'(nk4);
            ki <= 3'd0;
            rcon <= 8'h01;
            s <= blk_in;
            st <= S_KEY;
          end
        end
        S_KEY: begin
          for (int i = 0; i < 7; i++) w[i] <= w[i+1];
          w[7] <= nw;
          rkq[wi[5:2]][127-32*wi[1:0] -: 32] <= nw;
          if (ki == 3'd0) rcon <= xt(rcon);
          ki <= (ki == 3'(nk - 1)) ? 3'd0 : ki + 1'b1;
          wi <= wi + 1'b1;
          if (wi == total - 1) begin
            st <= S_RND; rnd <= 4'd0;
          end
        end
        S_RND: begin
          if (rnd == 4'd0) s <= s ^ rkq[0];
          else s <= aes_round(s, rkq[rnd], rnd == nr);
          rnd <= rnd + 1'b1;
          if (rnd == nr) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> st == S_IDLE) else $error("done while busy");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (start && st == S_IDLE) |=> st == S_KEY) else $error("no start");
  a_rnd: assert property (@(posedge clk) disable iff (rst)
    st == S_RND |-> rnd <= nr) else $error("round overrun");
`endif
endmodule

/* rtl/aofb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aofb_back
// Keystream generation and XOR; holds feedback block and output register.
// ----------------------------------------------------------------------------
module aofb_back (
  input  logic            clk,
  input  logic            rst,
  input  aofb_pkg::cfg_t  cfg,
  input  aofb_pkg::beat_t q_beat,
  input  logic            q_valid,
  output logic            q_pop,
  aofb_if.source          out_ch
);
  import aofb_pkg::*;

  logic [127:0] fb;
  logic [3:0]   pos;
  logic         ks_ok;
  logic         start, busy, done;
  logic [127:0] blk_in, blk_out;
  logic         need;
  logic         oready;

  aofb_core u_core (
    .clk, .rst, .start, .blk_in, .cfg, .busy, .done, .blk_out
  );

  assign need   = q_beat.restart || pos == 4'd0;
  assign blk_in = q_beat.restart ? cfg.iv : fb;
  assign start  = q_valid && need && !ks_ok && !busy && !done;
  assign oready = !out_ch.valid || out_ch.ready;
  assign q_pop  = q_valid && oready && (!need || ks_ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      fb <= '0; pos <= '0; ks_ok <= 1'b0; out_ch.valid <= 1'b0;
    end else begin
      out_ch.valid <= q_pop || (out_ch.valid && !out_ch.ready);
      if (done) fb <= blk_out;
      ks_ok <= done || (ks_ok && !(q_pop && need));
      if (q_pop) begin
        out_ch.data  <= q_beat.data ^ (need ? fb[127:120] : fb[127-8*pos -: 8]);
        out_ch.last  <= q_beat.last;
        out_ch.restart <= 1'b0;
        pos <= (need ? 4'd0 : pos) + 4'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data)) else $error("data moved");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (q_pop && need) |-> ks_ok) else $error("keystream not ready");
  a_start: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("start while busy");
`endif
endmodule

/* rtl/aes_ofb_stream_cipher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ofb_stream_cipher_top
// Byte-serial AES-OFB cipher with APB register port.
// ----------------------------------------------------------------------------
// Input channel: one byte per beat with restart and last flags; output
// channel: transformed byte and last flag. Registers at 8*i via APB.
// Bytes not at a block boundary need no AES run and pass through the
// queue and the output register. At a block boundary (position 0 or
// restart) the iterative AES engine first runs key expansion one word
// per cycle, then one round per cycle, and hands the result off as the
// new feedback block from which the next 16 keystream bytes are taken.
// A 4-entry queue lets input continue while the engine runs.
// Reset clears feedback block, position and queue; registers go to zero.
// A stalled receiver holds the output register and backs up into the queue.
// ----------------------------------------------------------------------------
module aes_ofb_stream_cipher_top #(
  parameter int QDepth = aofb_pkg::QueueDepth
) (
  input  logic                       clk,
  input  logic                       rst,
  aofb_if.sink                       in_ch,
  aofb_if.source                     out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aofb_pkg::AddrW-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import aofb_pkg::*;

  logic [63:0] k0, k1, k2, k3, ivh, ivl;
  logic [1:0]  kl;
  cfg_t        cfg;
  beat_t       q_beat;
  logic        q_valid, q_pop;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[5:3];
  assign cfg    = '{key: {k0, k1, k2, k3}, klen: kl, iv: {ivh, ivl}};

  always_ff @(posedge clk) begin
    if (rst) begin
      k0 <= '0; k1 <= '0; k2 <= '0; k3 <= '0; kl <= '0; ivh <= '0; ivl <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        RegKey0: k0 <= pwdata;
        RegKey1: k1 <= pwdata;
        RegKey2: k2 <= pwdata;
        RegKey3: k3 <= pwdata;
        RegKlen: kl <= pwdata[1:0];
        RegIvHi: ivh <= pwdata;
        RegIvLo: ivl <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RegKey0: prdata = k0;
      RegKey1: prdata = k1;
      RegKey2: prdata = k2;
      RegKey3: prdata = k3;
      RegKlen: prdata = {62'd0, kl};
      RegIvHi: prdata = ivh;
      RegIvLo: prdata = ivl;
      default: prdata = '0;
    endcase
  end

  aofb_front #(.Depth(QDepth)) u_front (
    .clk, .rst, .in_ch, .q_beat, .q_valid, .q_pop
  );

  aofb_back u_back (
    .clk, .rst, .cfg, .q_beat, .q_valid, .q_pop, .out_ch
  );
endmodule
